// ----- hw/rtl/uwr_pkg.sv -----
// ----------------------------------------------------------------------------
// uwr_pkg
// Shared types, constants and byte classification for the UTF-8 line wrapper.
// ----------------------------------------------------------------------------
package uwr_pkg;

  localparam int MAX_WIDTH      = 15;
  localparam int WORD_BUF_BYTES = 60;
  localparam int WB_AW          = $clog2(WORD_BUF_BYTES);
  localparam int WB_CW          = $clog2(WORD_BUF_BYTES + 1);
  localparam int LW_W           = 4;
  localparam int SAT_MAX        = 31;

  localparam logic [7:0] LEAD_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] TAB_CHAR   = 8'h09;
  localparam logic [7:0] CR_CHAR    = 8'h0D;

  // classified input item
  typedef struct packed {
    logic [7:0] data;
    logic       is_space;
    logic       is_lead;
    logic       eot;
  } cmd_t;

  // result item
  typedef struct packed {
    logic [7:0] data;
    logic       brk;
    logic       last;
  } res_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == SPACE_CHAR) || ((b >= TAB_CHAR) && (b <= CR_CHAR));
  endfunction

  // anything but a continuation byte starts a code point
  function automatic logic is_lead(input logic [7:0] b);
    return (b & LEAD_MASK) != CONT_TAG;
  endfunction

  function automatic logic [4:0] sat5(input logic [6:0] x);
    return (32'(x) > SAT_MAX) ? 5'(SAT_MAX) : x[4:0];
  endfunction

endpackage

// ----- hw/rtl/uwr_front.sv -----
// ----------------------------------------------------------------------------
// uwr_front
// Accepts input items, classifies each byte and queues it for the sequencer.
// ----------------------------------------------------------------------------
module uwr_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [7:0]    in_byte,
  input  logic          end_of_text,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output uwr_pkg::cmd_t item
);
  import uwr_pkg::*;

  cmd_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;
  cmd_t       cls;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign item    = q[rp];

  always_comb begin
    cls.data     = in_byte;
    cls.is_space = is_space(in_byte);
    cls.is_lead  = is_lead(in_byte);
    cls.eot      = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/uwr_outq.sv -----
// ----------------------------------------------------------------------------
// uwr_outq
// Two-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module uwr_outq (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  uwr_pkg::res_t din,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output uwr_pkg::res_t dout
);
  import uwr_pkg::*;

  res_t       q [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- hw/rtl/uwr_back.sv -----
// ----------------------------------------------------------------------------
// uwr_back
// Wrap sequencer: plans each phase of an item, emits its results through the
// pending register and replays held words from the word buffer.
// ----------------------------------------------------------------------------
module uwr_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [uwr_pkg::LW_W-1:0] line_width,
  input  logic                     cq_empty,
  input  uwr_pkg::cmd_t            cq_item,
  output logic                     cq_pop,
  input  logic                     oq_full,
  output logic                     oq_push,
  output uwr_pkg::res_t            oq_item
);
  import uwr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PLAN = 7'b0000010,
    S_PRE  = 7'b0000100,
    S_HRD  = 7'b0001000,
    S_HEM  = 7'b0010000,
    S_BYTE = 7'b0100000,
    S_END  = 7'b1000000
  } state_t;

  // add byte (or close word on whitespace), close word at end, final break
  typedef enum logic [1:0] {
    PH_ADD   = 2'd0,
    PH_END_W = 2'd1,
    PH_FLUSH = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STREAM = 2'd1,
    MODE_CHUNK  = 2'd2,
    MODE_HOLD   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    PRE_NONE  = 2'd0,
    PRE_BRK   = 2'd1,
    PRE_SPACE = 2'd2
  } pre_t;

  typedef struct packed {
    logic [7:0] data;
    logic       brk;
  } pend_t;

  state_t           state, state_next;
  phase_t           phase, phase_next;
  phase_t           adv_phase;
  state_t           adv_state;
  cmd_t             cmd;

  mode_t            mode, mode_next, m_eff;
  logic [WB_CW-1:0] wbytes, wbytes_next;
  logic [4:0]       wchars, wchars_next;
  logic [4:0]       lchars, lchars_next;
  logic             lopen, lopen_next;

  pre_t             pre, p_pre;
  logic [WB_CW-1:0] held_n, p_held;
  logic             post, p_post;
  logic             p_wr;
  logic [WB_CW-1:0] hidx;

  logic [7:0]       wbuf [WORD_BUF_BYTES];
  logic [7:0]       rdata;

  logic [LW_W-1:0]  w;
  logic [6:0]       sum7;
  logic             do_end;

  pend_t            pend;
  logic             pend_valid;
  logic             can_emit;
  logic             emit;
  pend_t            e_res;
  logic             end_push;

  assign w    = (32'(line_width) > MAX_WIDTH) ? LW_W'(MAX_WIDTH) : line_width;
  assign sum7 = 7'(lchars) + 7'(wchars) + 7'd1;

  // ---- phase planning: decisions and state updates ----
  always_comb begin
    p_pre       = PRE_NONE;
    p_held      = '0;
    p_post      = 1'b0;
    p_wr        = 1'b0;
    mode_next   = mode;
    wbytes_next = wbytes;
    wchars_next = wchars;
    lchars_next = lchars;
    lopen_next  = lopen;
    m_eff       = (mode == MODE_IDLE) ? (lopen ? MODE_HOLD : MODE_STREAM) : mode;
    do_end      = ((phase == PH_ADD) && cmd.is_space) || (phase == PH_END_W);
    if (phase == PH_FLUSH) begin
      if (lopen) begin
        p_pre       = PRE_BRK;
        lopen_next  = 1'b0;
        lchars_next = '0;
      end
    end else if (do_end) begin
      if (mode != MODE_IDLE) begin
        unique case (mode)
          MODE_HOLD: begin
            p_held = wbytes;
            if (sum7 <= 7'(w)) begin
              p_pre       = PRE_SPACE;
              lchars_next = sat5(sum7);
            end else begin
              p_pre       = PRE_BRK;
              lchars_next = wchars;
            end
          end
          MODE_CHUNK: begin
            p_pre       = PRE_BRK;
            lopen_next  = 1'b0;
            lchars_next = '0;
          end
          MODE_STREAM: begin
            if (!lopen) begin
              if (w == '0) begin
                p_pre = PRE_BRK;
              end else begin
                lopen_next  = 1'b1;
                lchars_next = wchars;
              end
            end
          end
          MODE_IDLE: ;
        endcase
        mode_next   = MODE_IDLE;
        wbytes_next = '0;
        wchars_next = '0;
      end
    end else begin
      mode_next = m_eff;
      if (m_eff == MODE_HOLD) begin
        if (cmd.is_lead && (sum7 + 7'd1 > 7'(w))) begin
          // held word can no longer fit: break, held bytes, this byte
          p_pre       = PRE_BRK;
          p_held      = wbytes;
          p_post      = 1'b1;
          lchars_next = sat5(7'(wchars) + 7'd1);
          wbytes_next = '0;
          wchars_next = '0;
          mode_next   = MODE_STREAM;
        end else if (wbytes < WB_CW'(WORD_BUF_BYTES)) begin
          p_wr        = 1'b1;
          wbytes_next = wbytes + 1'b1;
          if (cmd.is_lead) wchars_next = sat5(7'(wchars) + 7'd1);
        end
      end else if ((m_eff == MODE_STREAM) && lopen) begin
        p_post = 1'b1;
        if (cmd.is_lead) lchars_next = sat5(7'(lchars) + 7'd1);
      end else begin
        p_post = 1'b1;
        if (cmd.is_lead) begin
          if ((w != '0) && (wchars >= 5'(w))) begin
            p_pre       = PRE_BRK;
            wchars_next = 5'd1;
            mode_next   = MODE_CHUNK;
          end else begin
            wchars_next = sat5(7'(wchars) + 7'd1);
          end
        end
      end
    end
  end

  // ---- where to go once a phase has nothing more to emit ----
  always_comb begin
    adv_phase = phase;
    adv_state = S_END;
    unique case (phase)
      PH_ADD: begin
        if (cmd.eot) begin
          adv_state = S_PLAN;
          adv_phase = cmd.is_space ? PH_FLUSH : PH_END_W;
        end
      end
      PH_END_W: begin
        adv_state = S_PLAN;
        adv_phase = PH_FLUSH;
      end
      PH_FLUSH: ;
      default: ;
    endcase
  end

  // ---- emission: results go out through the pending register ----
  assign can_emit = !pend_valid || !oq_full;

  always_comb begin
    emit       = 1'b0;
    e_res.data = 8'h00;
    e_res.brk  = 1'b0;
    case (state)
      S_PRE: begin
        emit       = can_emit;
        e_res.brk  = (pre == PRE_BRK);
        e_res.data = (pre == PRE_SPACE) ? SPACE_CHAR : 8'h00;
      end
      S_HEM: begin
        emit       = can_emit;
        e_res.data = rdata;
      end
      S_BYTE: begin
        emit       = can_emit;
        e_res.data = cmd.data;
      end
      default: ;
    endcase
  end

  // last result of an item is known only when the item closes
  assign end_push     = (state == S_END) && pend_valid && !oq_full;
  assign oq_push      = (emit && pend_valid) || end_push;
  assign oq_item.data = pend.data;
  assign oq_item.brk  = pend.brk;
  assign oq_item.last = (state == S_END);
  assign cq_pop       = (state == S_IDLE) && !cq_empty;

  // ---- next state ----
  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      S_IDLE: begin
        if (!cq_empty) begin
          state_next = S_PLAN;
          phase_next = PH_ADD;
        end
      end
      S_PLAN: begin
        if (p_pre != PRE_NONE) begin
          state_next = S_PRE;
        end else if (p_held != '0) begin
          state_next = S_HRD;
        end else if (p_post) begin
          state_next = S_BYTE;
        end else begin
          state_next = adv_state;
          phase_next = adv_phase;
        end
      end
      S_PRE: begin
        if (can_emit) begin
          if (held_n != '0) begin
            state_next = S_HRD;
          end else if (post) begin
            state_next = S_BYTE;
          end else begin
            state_next = adv_state;
            phase_next = adv_phase;
          end
        end
      end
      S_HRD: state_next = S_HEM;
      S_HEM: begin
        if (can_emit) begin
          if (hidx + 1'b1 != held_n) begin
            state_next = S_HRD;
          end else if (post) begin
            state_next = S_BYTE;
          end else begin
            state_next = adv_state;
            phase_next = adv_phase;
          end
        end
      end
      S_BYTE: begin
        if (can_emit) begin
          state_next = adv_state;
          phase_next = adv_phase;
        end
      end
      S_END: begin
        if (!pend_valid || !oq_full) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase      <= PH_ADD;
      mode       <= MODE_IDLE;
      wbytes     <= '0;
      wchars     <= '0;
      lchars     <= '0;
      lopen      <= 1'b0;
      pend_valid <= 1'b0;
      pre        <= PRE_NONE;
      held_n     <= '0;
      post       <= 1'b0;
      hidx       <= '0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      if (state == S_PLAN) begin
        mode   <= mode_next;
        wbytes <= wbytes_next;
        wchars <= wchars_next;
        lchars <= lchars_next;
        lopen  <= lopen_next;
        pre    <= p_pre;
        held_n <= p_held;
        post   <= p_post;
        hidx   <= '0;
      end
      if ((state == S_HEM) && can_emit) hidx <= hidx + 1'b1;
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (end_push) begin
        pend_valid <= 1'b0;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cq_pop) cmd <= cq_item;
    if (emit)   pend <= e_res;
  end

  // ---- word buffer ----
  always_ff @(posedge clk) begin
    if ((state == S_PLAN) && p_wr) begin
      wbuf[wbytes[WB_AW-1:0]] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= wbuf[hidx[WB_AW-1:0]];
  end

endmodule

// ----- hw/rtl/utf8_greedy_word_wrap.sv -----
// ----------------------------------------------------------------------------
// utf8_greedy_word_wrap
// Greedy line wrapper for a UTF-8 byte stream: text bytes in, wrapped text
// bytes and line breaks out; width counted in code points.
// ----------------------------------------------------------------------------
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  input    | push / full      | in_byte[7:0], end_of_text
//  result   | empty / pop      | out_byte[7:0], line_break, last_of_run
//  config   | cfg_write        | cfg_data[3:0] -> line_width
//
//  Sequencing: the sequencer in uwr_back handles one item at a time. An item
//  with no result passes through pop, plan and close; each byte replayed from
//  the word buffer waits on a registered buffer read before it is emitted, and
//  an end-of-text item adds a plan step per extra phase.
//  Reset: rst is synchronous; both queues empty, no word or line pending,
//  line_width 0. The word buffer holds no reset value.
//  Stalls: a two-entry input queue and a two-entry result queue let input
//  and result sides stall on their own; a full result queue holds the
//  sequencer at its next emission while a result is pending.
// ----------------------------------------------------------------------------
module utf8_greedy_word_wrap (
  input  logic       clk,
  input  logic       rst,
  // input items
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       end_of_text,
  // result items
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       line_break,
  output logic       last_of_run,
  // line width register
  input  logic       cfg_write,
  input  logic [3:0] cfg_data
);
  import uwr_pkg::*;

  logic [LW_W-1:0] line_width;

  // front to back command queue
  logic cq_empty;
  logic cq_pop;
  cmd_t cq_item;

  // back to result queue
  logic oq_full;
  logic oq_push;
  res_t oq_item;
  res_t res;

  // width register; the user must write it only while the block is idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= '0;
    end else if (cfg_write) begin
      line_width <= cfg_data;
    end
  end

  uwr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .in_byte     (in_byte),
    .end_of_text (end_of_text),
    .full        (full),
    .pop         (cq_pop),
    .empty       (cq_empty),
    .item        (cq_item)
  );

  uwr_back u_back (
    .clk        (clk),
    .rst        (rst),
    .line_width (line_width),
    .cq_empty   (cq_empty),
    .cq_item    (cq_item),
    .cq_pop     (cq_pop),
    .oq_full    (oq_full),
    .oq_push    (oq_push),
    .oq_item    (oq_item)
  );

  uwr_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .din   (oq_item),
    .full  (oq_full),
    .pop   (pop),
    .empty (empty),
    .dout  (res)
  );

  assign out_byte    = res.data;
  assign line_break  = res.brk;
  assign last_of_run = res.last;

endmodule
